// File: rtl/u2l_pkg.sv
package u2l_pkg;

  // decoder mode codes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_TWO_2   = 3'd1,
    MODE_THREE_2 = 3'd2,
    MODE_THREE_3 = 3'd3,
    MODE_SKIP    = 3'd4
  } mode_e;

  // byte class boundaries
  localparam logic [7:0] CONT_BASE  = 8'h80;
  localparam logic [7:0] TWO_BASE   = 8'hC0;
  localparam logic [7:0] THREE_BASE = 8'hE0;
  localparam logic [7:0] FOUR_BASE  = 8'hF0;
  localparam logic [7:0] LATIN_LIMIT = 8'hC4;
  localparam logic [7:0] LEAD_MASK  = 8'h03;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // escaped characters
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;

  // decoded result of one input byte
  typedef struct packed {
    logic       emit;
    logic       esc;
    logic [7:0] data;
  } result_t;

endpackage

// File: rtl/u2l_in_if.sv
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

// File: rtl/u2l_out_if.sv
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/utf8_to_latin1_escaper_core.sv
// UTF-8 to Latin-1 converter with backslash escapes. Each input byte is
// decoded in the cycle it is accepted, so one byte is taken per cycle; a
// backslash or double quote yields two output bytes (a backslash prefix,
// then the character) and occupies the output register until both are taken,
// which, apart from the receiver holding off, is the only thing that slows
// the input below one byte a cycle.
// Results pass through a one-entry holding stage and the output register,
// so a result may wait on the output while the next byte is accepted.
// last_of_run marks the final output byte caused by an input byte. Bytes
// that decode to nothing (continuations, dropped sequences) give no output.
module utf8_to_latin1_escaper_core (
  input  logic clk_i,
  input  logic rst_ni,
  u2l_in_if.sink    in_i,
  u2l_out_if.source out_o
);

  u2l_pkg::mode_e   mode_q, mode_d;
  logic [7:0]       lead_q, lead_d;
  u2l_pkg::result_t res;

  logic             in_fire;
  logic             out_fire;
  logic             cont;
  logic [7:0]       b;

  logic             s1_valid_q;
  logic             s1_esc_q;
  logic [7:0]       s1_byte_q;
  logic             s1_move;

  logic             out_valid_q;
  logic             out_esc_q;
  logic [7:0]       out_byte_q;

  assign b        = in_i.in_byte;
  assign cont     = b[7];
  assign out_fire = out_valid_q && out_o.ready;
  assign s1_move  = s1_valid_q && (!out_valid_q || (out_fire && !out_esc_q));
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire  = in_i.valid && in_i.ready;

  // next mode and held lead
  always_comb begin
    mode_d = mode_q;
    lead_d = lead_q;
    if (in_fire) begin
      if (mode_q != u2l_pkg::MODE_IDLE && cont) begin
        unique case (mode_q)
          u2l_pkg::MODE_THREE_2: mode_d = u2l_pkg::MODE_THREE_3;
          u2l_pkg::MODE_SKIP:    mode_d = u2l_pkg::MODE_SKIP;
          default:               mode_d = u2l_pkg::MODE_IDLE;
        endcase
      end else begin
        // fresh byte
        if (b < u2l_pkg::TWO_BASE) begin
          mode_d = u2l_pkg::MODE_IDLE;
        end else if (b < u2l_pkg::THREE_BASE) begin
          lead_d = b;
          mode_d = u2l_pkg::MODE_TWO_2;
        end else if (b < u2l_pkg::FOUR_BASE) begin
          mode_d = u2l_pkg::MODE_THREE_2;
        end else begin
          mode_d = u2l_pkg::MODE_SKIP;
        end
      end
      if (in_i.chunk_end) begin
        mode_d = u2l_pkg::MODE_IDLE;
      end
    end
  end

  // result of the byte being accepted
  always_comb begin
    res = '0;
    if (mode_q != u2l_pkg::MODE_IDLE && cont) begin
      if (mode_q == u2l_pkg::MODE_TWO_2 && lead_q < u2l_pkg::LATIN_LIMIT) begin
        res.emit = 1'b1;
        res.data = {lead_q[1:0], b[5:0]};
      end
    end else if (b < u2l_pkg::CONT_BASE) begin
      res.emit = 1'b1;
      res.esc  = (b == u2l_pkg::CHAR_BSLASH) || (b == u2l_pkg::CHAR_DQUOTE);
      res.data = b;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= u2l_pkg::MODE_IDLE;
      lead_q <= '0;
    end else begin
      mode_q <= mode_d;
      lead_q <= lead_d;
    end
  end

  // holding stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_fire && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.emit) begin
      s1_esc_q  <= res.esc;
      s1_byte_q <= res.data;
    end
  end

  // output register, escape prefix goes out first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_esc_q   <= 1'b0;
    end else if (out_fire && out_esc_q) begin
      out_esc_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= s1_valid_q;
      out_esc_q   <= s1_valid_q && s1_esc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_byte_q <= s1_byte_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_esc_q ? u2l_pkg::CHAR_BSLASH : out_byte_q;
  assign out_o.last_of_run = !out_esc_q;

endmodule

// File: sim/utf8_latin1_checker.sv
module utf8_latin1_checker
  import u2l_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       chunk_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_of_run_i,
  output int         err_count_o,
  output int         pending_o,
  output int         results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } latin_byte_t;

  // latin-1 bytes still owed by the block, oldest first
  latin_byte_t latin_due_q[$];
  latin_byte_t due;

  // shadow decoder state
  mode_e      decode_mode;
  logic [7:0] held_lead;

  int mismatches = 0;
  int seen = 0;

  // advance the shadow decoder by one byte and queue the bytes it owes
  task automatic decode_utf8_byte(input logic [7:0] b, input logic end_mark);
    logic [7:0] outs [2];
    int         n;
    logic       fresh;
    n = 0;
    fresh = 1'b0;
    case (decode_mode)
      MODE_TWO_2: begin
        if (b[7]) begin
          if (held_lead < LATIN_LIMIT) begin
            outs[n] = ((held_lead & LEAD_MASK) << 6) | (b & CONT_MASK);
            n++;
          end
          decode_mode = MODE_IDLE;
        end else begin
          fresh = 1'b1;
        end
      end
      MODE_THREE_2: begin
        if (b[7]) decode_mode = MODE_THREE_3;
        else fresh = 1'b1;
      end
      MODE_THREE_3: begin
        if (b[7]) decode_mode = MODE_IDLE;
        else fresh = 1'b1;
      end
      MODE_SKIP: begin
        if (!b[7]) fresh = 1'b1;
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // a byte met with nothing pending, or one that broke off a sequence
    if (fresh) begin
      if (b < CONT_BASE) begin
        if (b == CHAR_BSLASH || b == CHAR_DQUOTE) begin
          outs[n] = CHAR_BSLASH;
          n++;
        end
        outs[n] = b;
        n++;
        decode_mode = MODE_IDLE;
      end else if (b < TWO_BASE) begin
        decode_mode = MODE_IDLE;
      end else if (b < THREE_BASE) begin
        held_lead = b;
        decode_mode = MODE_TWO_2;
      end else if (b < FOUR_BASE) begin
        decode_mode = MODE_THREE_2;
      end else begin
        decode_mode = MODE_SKIP;
      end
    end

    // chunk end throws away any partial sequence
    if (end_mark) decode_mode = MODE_IDLE;

    for (int i = 0; i < n; i++) begin
      latin_due_q.push_back(latin_byte_t'{ch: outs[i], last: (i == n - 1)});
    end
  endtask

  // compare each output transaction, then predict from each input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode = MODE_IDLE;
      held_lead = '0;
      latin_due_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (latin_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output byte %h last %b, nothing expected",
                   $time, out_byte_i, last_of_run_i);
        end else begin
          due = latin_due_q.pop_front();
          if (out_byte_i !== due.ch) begin
            mismatches++;
            $display("%0t: out_byte expected %h actual %h", $time, due.ch, out_byte_i);
          end
          if (last_of_run_i !== due.last) begin
            mismatches++;
            $display("%0t: last_of_run expected %b actual %b", $time, due.last,
                     last_of_run_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_utf8_byte(in_byte_i, chunk_end_i);
      pending_o = latin_due_q.size();
    end
  end

  assign err_count_o = mismatches;
  assign results_o   = seen;

endmodule

// File: sim/utf8_to_latin1_escaper_core_tb.sv
module utf8_to_latin1_escaper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u2l_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED  = 25;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  u2l_in_if  in_if ();
  u2l_out_if out_if ();

  utf8_to_latin1_escaper_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  int mismatches;
  int pending;
  int results;

  utf8_latin1_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_byte_i     (in_if.in_byte),
    .chunk_end_i   (in_if.chunk_end),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_byte_i    (out_if.out_byte),
    .last_of_run_i (out_if.last_of_run),
    .err_count_o   (mismatches),
    .pending_o     (pending),
    .results_o     (results)
  );

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit long_hold = 1'b0;
  int n_sent = 0;

  // directed bytes, chunk end in bit 8
  logic [8:0] directed_seq [0:N_DIRECTED-1] = '{
    // ascii extremes and both escaped characters
    9'h000, 9'h07F, 9'h05C, 9'h022,
    // two-byte pairs: e-acute, lowest decode, first lead that is dropped
    9'h0C3, 9'h0A9, 9'h0C0, 9'h080, 9'h0C4, 9'h080,
    // three-byte sequence, always dropped
    9'h0E2, 9'h082, 9'h0AC,
    // top lead skips all high bytes, a two-byte lead among them, until ascii
    9'h0FF, 9'h09F, 9'h098, 9'h080, 9'h0C3, 9'h061,
    // lead cut short by an escaped character
    9'h0C2, 9'h05C, 9'h0E2, 9'h022,
    // lead on a chunk end, then a stray continuation
    9'h1C3, 9'h1A9
  };

  function automatic logic chunk_mark();
    return ($urandom_range(0, 15) == 0);
  endfunction

  // offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.chunk_end <= e;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // one character's worth of input: mostly well-formed, some broken or noise
  task automatic send_random_unit();
    int         kind;
    int         n_cont;
    logic [7:0] lead;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        send_byte(8'($urandom_range(0, 127)), chunk_mark());
      end
      3: begin
        send_byte(($urandom_range(0, 1) != 0) ? CHAR_BSLASH : CHAR_DQUOTE, chunk_mark());
      end
      4, 5: begin
        if ($urandom_range(0, 1) != 0) lead = 8'($urandom_range(8'hC0, 8'hC3));
        else lead = 8'($urandom_range(8'hC4, 8'hDF));
        send_byte(lead, chunk_mark());
        send_byte(8'($urandom_range(8'h80, 8'hBF)), chunk_mark());
      end
      6: begin
        send_byte(8'($urandom_range(8'hE0, 8'hEF)), chunk_mark());
        repeat (2) send_byte(8'($urandom_range(8'h80, 8'hBF)), chunk_mark());
      end
      7: begin
        send_byte(8'($urandom_range(8'hF0, 8'hFF)), chunk_mark());
        n_cont = $urandom_range(1, 4);
        repeat (n_cont) send_byte(8'($urandom_range(8'h80, 8'hFF)), chunk_mark());
      end
      8: begin
        // lead with no continuation after it
        send_byte(8'($urandom_range(8'hC0, 8'hFF)), chunk_mark());
        send_byte(8'($urandom_range(0, 127)), chunk_mark());
      end
      default: begin
        send_byte(8'($urandom_range(0, 255)), chunk_mark());
      end
    endcase
  endtask

  // stop offering until every predicted byte has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall = HOLD_CYCLES;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    in_if.valid     <= 1'b0;
    in_if.in_byte   <= '0;
    in_if.chunk_end <= 1'b0;
    rst_ni          <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

    send_idle = 1'b1;
    recv_idle = 1'b1;
    while (n_sent < 250) send_random_unit();

    // keep offering while the output is held off so the block backs up
    send_idle = 1'b0;
    long_hold = 1'b1;
    while (n_sent < 300) send_random_unit();
    send_idle = 1'b1;
    drain();

    while (n_sent < 550) send_random_unit();

    // full rate on both sides to the end
    send_idle = 1'b0;
    recv_idle = 1'b0;
    while (n_sent < 700) send_random_unit();
    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d input bytes (%0d directed) and %0d checked output bytes",
             n_sent, N_DIRECTED, results);
    $display("with a %0d-cycle output hold-off, a mid-run drain and a no-idle finish",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
